### hw/rtl/rcab_pkg.sv
// Shared types and constants for the cumulative-ack reorder buffer.
// Used by rcab_ctrl, rcab_dp, the top level and the port checker.
package rcab_pkg;

    localparam int SEQ_W = 31;
    localparam int TAG_W = 16;
    localparam int LEN_W = 14;

    // Slot count: the slot index is the low bits of the id, so keep it a power of two
    localparam int SLOT_COUNT = 32;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);

    localparam logic [SEQ_W-1:0] SEQ_MAX   = {SEQ_W{1'b1}};
    localparam logic [SEQ_W-1:0] SEQ_FIRST = SEQ_W'(1);

    // Result kinds
    localparam logic KIND_DELIVER = 1'b0;
    localparam logic KIND_ACK     = 1'b1;

    // Input item: one packet descriptor
    typedef struct packed {
        logic [SEQ_W-1:0] seq_id;
        logic             is_final;
        logic [TAG_W-1:0] payload_tag;
        logic [LEN_W-1:0] payload_len;
    } rcab_in_t;

    // Result item
    typedef struct packed {
        logic             kind;
        logic [TAG_W-1:0] out_tag;
        logic [LEN_W-1:0] out_len;
        logic [SEQ_W-1:0] ack_id;
        logic             done_res;
        logic             last;
    } rcab_out_t;

    // One buffered packet in the slot memory
    typedef struct packed {
        logic [SEQ_W-1:0] seq_id;
        logic             is_final;
        logic [TAG_W-1:0] tag;
        logic [LEN_W-1:0] len;
    } rcab_slot_t;

    // Controller to datapath
    typedef struct packed {
        logic load_in;       // capture the incoming item
        logic rd_exp;        // slot memory read address: expected id slot, else item slot
        logic store;         // write item into its slot, set valid
        logic clr_seq_slot;  // clear valid of the item's slot
        logic clr_exp_slot;  // clear valid of the expected id's slot
        logic advance;       // expected id + 1, saturating
        logic set_done;      // final packet consumed
        logic emit_in;       // deliver the held item
        logic emit_mem;      // deliver the buffered packet just read
        logic emit_ack;      // cumulative ack, last result of the item
    } rcab_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic seq_eq;        // item id equals expected id
        logic seq_gt;        // item id is ahead of expected id
        logic fin;           // item is the final packet
        logic seq_slot_vld;  // item's slot is occupied
        logic stale_hit;     // item's slot holds this same id
        logic drain_hit;     // expected id's slot holds the expected id
        logic drain_final;   // that buffered packet is the final one
        logic out_free;      // result register can take a new result
    } rcab_sts_t;

    // Controller states
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_EVAL  = 6'b000010,
        S_STALE = 6'b000100,
        S_FETCH = 6'b001000,
        S_DRAIN = 6'b010000,
        S_ACK   = 6'b100000
    } rcab_state_t;

endpackage

### hw/rtl/rcab_ctrl.sv
// Controller state machine for the reorder buffer.
// Depends on rcab_pkg; drives rcab_dp through rcab_cmd_t, reads rcab_sts_t.
module rcab_ctrl
    import rcab_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      pkt_valid,
    output logic      pkt_ready,
    input  rcab_sts_t sts,
    output rcab_cmd_t cmd
);

    rcab_state_t state_reg, state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign pkt_ready = (state_reg == S_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (pkt_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_EVAL;
                end
            end
            S_EVAL:
            begin
                // memory read of the item's slot is under way for S_STALE
                if (sts.out_free)
                begin
                    if (sts.seq_eq && !sts.fin)
                    begin
                        cmd.emit_in = 1'b1;
                        cmd.advance = 1'b1;
                        state_next  = S_STALE;
                    end
                    else
                    begin
                        // ack right away: old, ahead, or in-order final
                        cmd.emit_ack = 1'b1;
                        if (sts.seq_eq)
                        begin
                            cmd.set_done = 1'b1;
                            cmd.advance  = 1'b1;
                        end
                        if (sts.seq_gt && !sts.seq_slot_vld)
                        begin
                            cmd.store = 1'b1;
                        end
                        state_next = S_IDLE;
                    end
                end
            end
            S_STALE:
            begin
                // drop a leftover copy of the id just delivered
                cmd.clr_seq_slot = sts.stale_hit;
                state_next       = S_FETCH;
            end
            S_FETCH:
            begin
                cmd.rd_exp = 1'b1;
                state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                // keep reading the expected slot while a result waits
                cmd.rd_exp = 1'b1;
                if (!sts.drain_hit)
                begin
                    state_next = S_ACK;
                end
                else if (sts.drain_final)
                begin
                    // buffered final: no delivery, drain ends
                    cmd.clr_exp_slot = 1'b1;
                    cmd.set_done     = 1'b1;
                    cmd.advance      = 1'b1;
                    state_next       = S_ACK;
                end
                else if (sts.out_free)
                begin
                    cmd.emit_mem     = 1'b1;
                    cmd.clr_exp_slot = 1'b1;
                    cmd.advance      = 1'b1;
                    state_next       = S_FETCH;
                end
            end
            S_ACK:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_ack = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### hw/rtl/rcab_dp.sv
// Datapath for the reorder buffer: expected id, done flag, slot valid bits,
// slot memory and the result register. Depends on rcab_pkg.
module rcab_dp
    import rcab_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  rcab_in_t  pkt,
    input  logic      res_ready,
    output logic      res_valid,
    output rcab_out_t res,
    input  rcab_cmd_t cmd,
    output rcab_sts_t sts
);

    rcab_in_t                in_reg;
    logic [SEQ_W-1:0]        exp_reg, exp_next;
    logic                    done_reg, done_next;
    logic [SLOT_COUNT-1:0]   slot_vld_reg, slot_vld_next;
    rcab_slot_t              slot_mem [SLOT_COUNT];
    rcab_slot_t              rd_reg;
    logic                    res_valid_reg, res_valid_next;
    rcab_out_t               res_reg, res_next;

    logic [SLOT_W-1:0]       seq_slot;
    logic [SLOT_W-1:0]       exp_slot;
    logic [SLOT_W-1:0]       rd_addr;
    logic [SEQ_W-1:0]        exp_inc;
    logic                    out_free;
    rcab_slot_t              wr_entry;

    assign seq_slot = in_reg.seq_id[SLOT_W-1:0];
    assign exp_slot = exp_reg[SLOT_W-1:0];
    assign rd_addr  = cmd.rd_exp ? exp_slot : seq_slot;
    assign exp_inc  = (exp_reg == SEQ_MAX) ? exp_reg : exp_reg + SEQ_W'(1);
    assign out_free = !res_valid_reg || res_ready;

    // Held input item
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            in_reg <= pkt;
        end
    end

    // Slot memory: one write, one registered read
    assign wr_entry = '{seq_id:   in_reg.seq_id,
                        is_final: in_reg.is_final,
                        tag:      in_reg.payload_tag,
                        len:      in_reg.payload_len};

    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            slot_mem[seq_slot] <= wr_entry;
        end
        rd_reg <= slot_mem[rd_addr];
    end

    // Expected id, done flag, valid bits
    always_comb
    begin
        exp_next      = cmd.advance ? exp_inc : exp_reg;
        done_next     = done_reg | cmd.set_done;
        slot_vld_next = slot_vld_reg;
        if (cmd.store)
        begin
            slot_vld_next[seq_slot] = 1'b1;
        end
        if (cmd.clr_seq_slot)
        begin
            slot_vld_next[seq_slot] = 1'b0;
        end
        if (cmd.clr_exp_slot)
        begin
            slot_vld_next[exp_slot] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_reg      <= SEQ_FIRST;
            done_reg     <= 1'b0;
            slot_vld_reg <= '0;
        end
        else
        begin
            exp_reg      <= exp_next;
            done_reg     <= done_next;
            slot_vld_reg <= slot_vld_next;
        end
    end

    // Result register
    always_comb
    begin
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !res_ready;
        if (cmd.emit_in || cmd.emit_mem)
        begin
            res_valid_next    = 1'b1;
            res_next.kind     = KIND_DELIVER;
            res_next.out_tag  = cmd.emit_mem ? rd_reg.tag : in_reg.payload_tag;
            res_next.out_len  = cmd.emit_mem ? rd_reg.len : in_reg.payload_len;
            res_next.ack_id   = '0;
            res_next.done_res = done_reg;
            res_next.last     = 1'b0;
        end
        else if (cmd.emit_ack)
        begin
            // ack carries the expected id after this cycle's update, minus one
            res_valid_next    = 1'b1;
            res_next.kind     = KIND_ACK;
            res_next.out_tag  = '0;
            res_next.out_len  = '0;
            res_next.ack_id   = exp_next - SEQ_W'(1);
            res_next.done_res = done_next;
            res_next.last     = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // Status to the controller
    always_comb
    begin
        sts.seq_eq       = (in_reg.seq_id == exp_reg);
        sts.seq_gt       = (in_reg.seq_id > exp_reg);
        sts.fin          = in_reg.is_final;
        sts.seq_slot_vld = slot_vld_reg[seq_slot];
        sts.stale_hit    = slot_vld_reg[seq_slot] && (rd_reg.seq_id == in_reg.seq_id);
        sts.drain_hit    = slot_vld_reg[exp_slot] && (rd_reg.seq_id == exp_reg);
        sts.drain_final  = rd_reg.is_final;
        sts.out_free     = out_free;
    end

endmodule

### hw/rtl/reorder_buffer_cumulative_ack.sv
// Reorder buffer with cumulative ack, top level.
// Old, ahead or in-order final packet: handled in S_IDLE and S_EVAL, ack registered from S_EVAL.
// In-order packet: S_IDLE, S_EVAL, S_STALE, then S_FETCH and S_DRAIN per drained buffered packet
// and once more to end the drain, then S_ACK; each drained slot costs one read of the slot memory
// (registered read) plus its check. Output stalls hold the controller only when a result is waiting.
// Reset (rst_n, async) clears control, slot valid bits, done, and sets the expected id to 1; no clearing pass.
module reorder_buffer_cumulative_ack
    import rcab_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      pkt_valid,
    output logic      pkt_ready,
    input  rcab_in_t  pkt,
    output logic      res_valid,
    input  logic      res_ready,
    output rcab_out_t res
);

    rcab_cmd_t cmd;
    rcab_sts_t sts;

    rcab_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .pkt_valid (pkt_valid),
        .pkt_ready (pkt_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    rcab_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .pkt       (pkt),
        .res_ready (res_ready),
        .res_valid (res_valid),
        .res       (res),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

### hw/rtl/rcab_checker.sv
// Port-level checks for the reorder buffer top level, bound in below.
// Depends on rcab_pkg.
module rcab_checker
    import rcab_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      pkt_valid,
    input logic      pkt_ready,
    input logic      res_valid,
    input logic      res_ready,
    input rcab_out_t res
);

    // A stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("result changed while stalled");

    // The ack and only the ack closes an item
    a_ack_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res.last == (res.kind == KIND_ACK)))
        else $error("last flag does not match result kind");

    // Unused fields are zero for each kind
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> ((res.kind == KIND_ACK) ? (res.out_tag == '0 && res.out_len == '0)
                                             : (res.ack_id == '0)))
        else $error("unused result field not zero");

    // Done never falls once shown
    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && res.done_res |=> !res_valid || res.done_res)
        else $error("done flag dropped");

    // One item at a time: busy right after taking one
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        pkt_valid && pkt_ready |=> !pkt_ready)
        else $error("item taken while another is in work");

endmodule

bind reorder_buffer_cumulative_ack rcab_checker u_rcab_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .pkt_valid (pkt_valid),
    .pkt_ready (pkt_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
);

### tb/rcab_delivery_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the cumulative-ack reorder buffer: keeps its own copy of the
// window state, predicts deliveries and acks per packet, and compares results in order.
// Depends on rcab_pkg for the item types and sizes.
module rcab_delivery_checker
    import rcab_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      pkt_valid,
    input  logic      pkt_ready,
    input  rcab_in_t  pkt,
    input  logic      res_valid,
    input  logic      res_ready,
    input  rcab_out_t res,
    output int        mismatches,
    output int        results_owed
);

    // Shadow of the receive window
    rcab_slot_t       held_pkt [SLOT_COUNT];
    logic             held_vld [SLOT_COUNT];
    logic [SEQ_W-1:0] want_id;
    logic             xfer_done;
    rcab_out_t        owed_q[$];

    // Expected id moves up by one and sticks at the top
    function automatic void bump_want_id();
        if (want_id != SEQ_MAX)
            want_id = want_id + 1'b1;
    endfunction

    function automatic void owe_delivery(input logic [TAG_W-1:0] tag,
                                         input logic [LEN_W-1:0] len);
        rcab_out_t r;
        r          = '0;
        r.kind     = KIND_DELIVER;
        r.out_tag  = tag;
        r.out_len  = len;
        r.done_res = xfer_done;
        owed_q.push_back(r);
    endfunction

    // Work out everything one packet causes, ack last
    function automatic void predict_packet(input rcab_in_t p);
        int        s;
        int        d;
        logic      draining;
        rcab_out_t a;
        s = int'(p.seq_id % SLOT_COUNT);
        if (p.seq_id == want_id)
        begin
            if (p.is_final)
            begin
                xfer_done = 1'b1;
                bump_want_id();
            end
            else
            begin
                owe_delivery(p.payload_tag, p.payload_len);
                bump_want_id();
                // stale copy of this same packet left behind by an earlier drain stop
                if (held_vld[s] && held_pkt[s].seq_id == p.seq_id)
                    held_vld[s] = 1'b0;
                draining = 1'b1;
                for (int n = 0; n < SLOT_COUNT && draining; n++)
                begin
                    d = int'(want_id % SLOT_COUNT);
                    if (!held_vld[d] || held_pkt[d].seq_id != want_id)
                        draining = 1'b0;
                    else
                    begin
                        held_vld[d] = 1'b0;
                        if (held_pkt[d].is_final)
                        begin
                            // buffered final: no delivery, drain ends here
                            xfer_done = 1'b1;
                            bump_want_id();
                            draining  = 1'b0;
                        end
                        else
                        begin
                            owe_delivery(held_pkt[d].tag, held_pkt[d].len);
                            bump_want_id();
                        end
                    end
                end
            end
        end
        else if (p.seq_id > want_id)
        begin
            // ahead of the window: keep it only if its slot is free
            if (!held_vld[s])
            begin
                held_vld[s]          = 1'b1;
                held_pkt[s].seq_id   = p.seq_id;
                held_pkt[s].is_final = p.is_final;
                held_pkt[s].tag      = p.payload_tag;
                held_pkt[s].len      = p.payload_len;
            end
        end
        a          = '0;
        a.kind     = KIND_ACK;
        a.ack_id   = want_id - 1'b1;
        a.done_res = xfer_done;
        a.last     = 1'b1;
        owed_q.push_back(a);
    endfunction

    // Results are checked before new predictions: a packet cannot answer on its own edge
    always @(posedge clk or negedge rst_n)
    begin
        rcab_out_t e;
        if (!rst_n)
        begin
            want_id   = SEQ_FIRST;
            xfer_done = 1'b0;
            for (int i = 0; i < SLOT_COUNT; i++)
                held_vld[i] = 1'b0;
            owed_q.delete();
            mismatches   = 0;
            results_owed = 0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                if (owed_q.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: unexpected result kind=%0d tag=%h len=%h ack=%h done=%0d last=%0d",
                                 $time, res.kind, res.out_tag, res.out_len, res.ack_id,
                                 res.done_res, res.last);
                    mismatches++;
                end
                else
                begin
                    e = owed_q.pop_front();
                    if (res.kind !== e.kind || res.out_tag !== e.out_tag ||
                        res.out_len !== e.out_len || res.ack_id !== e.ack_id ||
                        res.done_res !== e.done_res || res.last !== e.last)
                    begin
                        if (mismatches < 10)
                        begin
                            $display("%0t: expected kind=%0d tag=%h len=%h ack=%h done=%0d last=%0d",
                                     $time, e.kind, e.out_tag, e.out_len, e.ack_id,
                                     e.done_res, e.last);
                            $display("%0t:      got kind=%0d tag=%h len=%h ack=%h done=%0d last=%0d",
                                     $time, res.kind, res.out_tag, res.out_len, res.ack_id,
                                     res.done_res, res.last);
                        end
                        mismatches++;
                    end
                end
            end
            if (pkt_valid && pkt_ready)
                predict_packet(pkt);
            results_owed = owed_q.size();
        end
    end

endmodule

### tb/tb_reorder_buffer_cumulative_ack.sv
`timescale 1ns / 1ps
// Top of the reorder buffer testbench: clock, reset, packet stimulus and result backpressure.
// Depends on rcab_pkg, the block itself and rcab_delivery_checker.
module tb_reorder_buffer_cumulative_ack;
    import rcab_pkg::*;

    localparam int TOTAL_ITEMS = 266;
    localparam int CALM_ITEMS  = 40;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      pkt_valid = 1'b0;
    logic      pkt_ready;
    rcab_in_t  pkt       = '0;
    logic      res_valid;
    logic      res_ready = 1'b0;
    rcab_out_t res;

    int mismatches;
    int results_owed;

    int pkts_sent = 0;
    int next_base = 1;   // first id of the next window
    bit calm      = 1'b0;
    int tx_quiet  = 0;
    int rx_hold   = 0;
    int rx_window = 0;
    bit rx_stalls = 1'b0;

    reorder_buffer_cumulative_ack u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .pkt_valid (pkt_valid),
        .pkt_ready (pkt_ready),
        .pkt       (pkt),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    rcab_delivery_checker u_chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .pkt_valid    (pkt_valid),
        .pkt_ready    (pkt_ready),
        .pkt          (pkt),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res),
        .mismatches   (mismatches),
        .results_owed (results_owed)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Result side: windows with or without stall bursts, none near the end
    always @(negedge clk)
    begin
        if (rx_window == 0)
        begin
            rx_window = $urandom_range(300, 40);
            rx_stalls = ($urandom_range(2, 0) != 0);
        end
        rx_window--;
        if (rx_hold > 0)
        begin
            rx_hold--;
            res_ready <= 1'b0;
        end
        else if (!calm && rx_stalls && $urandom_range(7, 0) == 0)
        begin
            rx_hold = $urandom_range(16, 0);
            res_ready <= 1'b0;
        end
        else
            res_ready <= 1'b1;
    end

    function automatic rcab_in_t mk_pkt(input logic [SEQ_W-1:0] seq, input logic fin,
                                        input logic [TAG_W-1:0] tag,
                                        input logic [LEN_W-1:0] len);
        rcab_in_t p;
        p.seq_id      = seq;
        p.is_final    = fin;
        p.payload_tag = tag;
        p.payload_len = len;
        return p;
    endfunction

    // Random payload, extremes now and then
    function automatic rcab_in_t rand_pkt(input logic [SEQ_W-1:0] seq, input logic fin);
        case ($urandom_range(7, 0))
            0: return mk_pkt(seq, fin, '0, '0);
            1: return mk_pkt(seq, fin, '1, '1);
            default: return mk_pkt(seq, fin, TAG_W'($urandom()), LEN_W'($urandom()));
        endcase
    endfunction

    // One item on the packet channel, then an optional idle burst
    task automatic send_packet(input rcab_in_t p);
        int gap;
        @(negedge clk);
        pkt       <= p;
        pkt_valid <= 1'b1;
        @(posedge clk);
        while (!pkt_ready)
            @(posedge clk);
        pkts_sent++;
        calm = (pkts_sent >= TOTAL_ITEMS - CALM_ITEMS);
        gap  = 0;
        if (calm)
            gap = 0;
        else if (tx_quiet > 0)
            tx_quiet--;
        else if ($urandom_range(9, 0) == 0)
            tx_quiet = $urandom_range(60, 20);
        else if ($urandom_range(3, 0) == 0)
            gap = $urandom_range(17, 1);
        if (gap > 0)
        begin
            @(negedge clk);
            pkt_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Hold off until every predicted result has come out
    task automatic wait_results_drained();
        @(negedge clk);
        pkt_valid <= 1'b0;
        while (results_owed != 0)
            @(negedge clk);
    endtask

    // One window of ids next_base .. next_base+n-1 in shuffled order, mixed with
    // duplicates, old ids and far ids that land on an occupied slot. Of the ids sent for the first time
    // only the last may be final, so the window always closes with every slot empty again.
    task automatic run_window(input int n, input bit fin_last, input bit head_last);
        bit               sent [0:32];
        int               front;
        int               left;
        int               idx;
        int               pick;
        int               cur;
        logic [SEQ_W-1:0] sid;
        logic [SEQ_W-1:0] far;
        for (idx = 0; idx < n; idx++)
            sent[idx] = 1'b0;
        front = 0;
        left  = n;
        while (left > 0)
        begin
            cur  = next_base + front;
            pick = $urandom_range(11, 0);
            if (pick == 0 && left < n)
            begin
                // duplicate: either old or sitting in its slot already
                do
                    idx = $urandom_range(n - 1, 0);
                while (!sent[idx]);
                send_packet(rand_pkt(SEQ_W'(next_base + idx), 1'($urandom_range(1, 0))));
            end
            else if (pick == 1)
                send_packet(rand_pkt(SEQ_W'($urandom_range(cur - 1, 0)),
                                     1'($urandom_range(1, 0))));
            else if (pick == 2 && n - left - front > 0)
            begin
                // far id sharing the slot of a buffered packet
                do
                    idx = $urandom_range(n - 1, front + 1);
                while (!sent[idx]);
                sid = SEQ_W'(next_base + idx);
                far = SEQ_W'($urandom());
                if ($urandom_range(3, 0) == 0)
                    far[SEQ_W-1:SLOT_W] = '1;
                far[SLOT_W-1:0] = sid[SLOT_W-1:0];
                if (far >= cur && far < next_base + n)
                    far = sid;
                send_packet(rand_pkt(far, 1'($urandom_range(1, 0))));
            end
            else
            begin
                do
                    idx = $urandom_range(n - 1, 0);
                while (sent[idx] || (head_last && idx == 0 && left > 1));
                sent[idx] = 1'b1;
                left--;
                send_packet(rand_pkt(SEQ_W'(next_base + idx), fin_last && idx == n - 1));
                while (front < n && sent[front])
                    front++;
            end
        end
        next_base += n;
    endtask

    initial
    begin
        int n;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // zero id, dropped even when marked final
        send_packet(mk_pkt(31'd0, 1'b1, '1, '1));
        // buffer 2, then 34 hits the same occupied slot
        send_packet(mk_pkt(31'd2, 1'b0, '0, '0));
        send_packet(mk_pkt(31'd34, 1'b0, 16'h1234, 14'h0005));
        // in order with maximum payload, drains 2
        send_packet(mk_pkt(31'd1, 1'b0, '1, '1));
        send_packet(mk_pkt(31'd1, 1'b0, 16'h5a5a, 14'h2a2a));
        // far id with all high bits set on an occupied slot
        send_packet(mk_pkt(31'd5, 1'b0, 16'h00ff, 14'h1000));
        send_packet(mk_pkt(31'h7fffffe5, 1'b1, 16'hffff, 14'h0001));
        send_packet(mk_pkt(31'd3, 1'b0, 16'h8000, 14'h2000));
        send_packet(mk_pkt(31'd4, 1'b0, 16'h0001, 14'h3fff));
        // buffered final stops the drain and leaves 8 behind; resent 8 clears it
        send_packet(mk_pkt(31'd8, 1'b0, 16'hbeef, 14'h0123));
        send_packet(mk_pkt(31'd7, 1'b1, 16'hdead, 14'h0042));
        send_packet(mk_pkt(31'd6, 1'b0, 16'hcafe, 14'h0777));
        send_packet(mk_pkt(31'd8, 1'b0, 16'hf00d, 14'h0999));
        // in-order final, then traffic keeps flowing after done
        send_packet(mk_pkt(31'd9, 1'b1, 16'h1111, 14'h0111));
        send_packet(mk_pkt(31'd11, 1'b0, 16'h2222, 14'h0222));
        send_packet(mk_pkt(31'd10, 1'b0, 16'h3333, 14'h0333));
        next_base = 12;
        wait_results_drained();

        // full window with its head last: longest drain
        run_window(33, 1'b0, 1'b1);
        while (pkts_sent < TOTAL_ITEMS)
        begin
            pick_size: begin
                n = $urandom_range(99, 0);
                if (n < 65)
                    n = $urandom_range(6, 1);
                else if (n < 93)
                    n = $urandom_range(20, 7);
                else
                    n = $urandom_range(33, 21);
            end
            run_window(n, $urandom_range(3, 0) == 0, $urandom_range(4, 0) == 0);
        end
        @(negedge clk);
        pkt_valid <= 1'b0;

        wait_results_drained();
        repeat (80) @(posedge clk);
        if (mismatches == 0 && results_owed == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #12000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
